>>> design/xme_pkg.sv
package xme_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int DISP_W_MIN   = (OFFSET_WIDTH < 32) ? OFFSET_WIDTH : 32;
    localparam int DISP_W       = (DISP_W_MIN < 8) ? 8 : DISP_W_MIN;

    localparam int MAX_BYTES = 10;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_len;

    typedef enum logic [2:0] {
        FORM_RR   = 3'd0,
        FORM_BASE = 3'd1,
        FORM_ABS  = 3'd2,
        FORM_IMM  = 3'd3
    } t_form;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNSUPP  = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam t_byte REX_W      = 8'b0100_1000;
    localparam t_byte OP_MOV_RM  = 8'h89;
    localparam t_byte OP_MOV_LD  = 8'h8B;
    localparam t_byte OP_MOV_MOF = 8'hA1;
    localparam t_byte OP_MOV_IMM = 8'hB8;
    localparam t_byte OP_MOV_I32 = 8'hC7;
    localparam t_byte SIB_RSP    = 8'h24;
    localparam t_byte SIB_ABS    = 8'h25;
    localparam logic [1:0] MOD_IND  = 2'b00;
    localparam logic [1:0] MOD_D8   = 2'b01;
    localparam logic [1:0] MOD_D32  = 2'b10;
    localparam logic [1:0] MOD_REG  = 2'b11;
    localparam logic [2:0] RM_SIB   = 3'b100;
    localparam logic [2:0] REG_RSP  = 3'd4;
    localparam logic [2:0] REG_RBP  = 3'd5;
    localparam logic [2:0] REG_RAX  = 3'd0;

endpackage

>>> design/xme_if.sv
interface xme_in_if import xme_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [2:0]  dst_reg;
    logic [2:0]  src_reg;
    logic signed [63:0] operand_value;

    modport source (output valid, opcode, dst_reg, src_reg, operand_value, input ready);
    modport sink   (input valid, opcode, dst_reg, src_reg, operand_value, output ready);
endinterface

interface xme_out_if import xme_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  code_byte;
    logic [31:0] item_offset;
    logic        last_byte;
    logic [1:0]  status;

    modport source (output valid, code_byte, item_offset, last_byte, status, input ready);
    modport sink   (input valid, code_byte, item_offset, last_byte, status, output ready);
endinterface

>>> design/x86_64_mov_encoder_core.sv
// An item is registered in the input stage at acceptance and moves into the byte serializer
// when the serializer is free; its first byte is then offered.
// Bytes go out one per cycle while o_out.ready is high; an instruction is 3 to 10 bytes long,
// an error item a single byte. The next item is encoded while the current one drains.
// Reset (i_rst_n low, synchronous) empties both stages and clears the text offset to 0.
module x86_64_mov_encoder_core import xme_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xme_in_if.sink       i_in,
    xme_out_if.source    o_out
);

    logic               r_a_valid;
    logic [2:0]         r_a_opcode;
    logic [2:0]         r_a_dst;
    logic [2:0]         r_a_src;
    logic [63:0]        r_a_val;

    logic               r_b_valid;
    t_byte              r_b_buf [MAX_BYTES];
    t_len               r_b_len;
    t_len               r_b_idx;
    logic [31:0]        r_b_offset;
    t_status            r_b_status;

    logic [31:0]        r_text_offset;

    t_byte              enc_buf [MAX_BYTES];
    t_len               enc_len;
    t_status            enc_status;

    logic               b_last;
    logic               b_free;
    logic               a_adv;
    logic               fits8;
    logic               fits32;
    logic               fits_disp;
    logic [1:0]         mod;
    t_len               n;

    assign fits8     = (&r_a_val[63:7])  | ~(|r_a_val[63:7]);
    assign fits32    = (&r_a_val[63:31]) | ~(|r_a_val[63:31]);
    assign fits_disp = (&r_a_val[63:DISP_W-1]) | ~(|r_a_val[63:DISP_W-1]);

    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            enc_buf[k] = '0;
        end
        enc_len    = 4'd1;
        enc_status = ST_OK;
        mod        = MOD_IND;
        n          = '0;
        unique case (r_a_opcode)
            FORM_RR: begin
                enc_buf[0] = REX_W;
                enc_buf[1] = OP_MOV_RM;
                enc_buf[2] = {MOD_REG, r_a_src, r_a_dst};
                enc_len    = 4'd3;
            end
            FORM_BASE: begin
                if (!fits_disp) begin
                    enc_status = ST_RANGE;
                end else begin
                    if (r_a_val == 64'd0 && r_a_src != REG_RBP) begin
                        mod = MOD_IND;
                    end else if (fits8) begin
                        mod = MOD_D8;
                    end else begin
                        mod = MOD_D32;
                    end
                    enc_buf[0] = REX_W;
                    enc_buf[1] = OP_MOV_LD;
                    enc_buf[2] = {mod, r_a_dst, r_a_src};
                    n = 4'd3;
                    if (r_a_src == REG_RSP) begin
                        enc_buf[n] = SIB_RSP;
                        n = n + 4'd1;
                    end
                    if (mod == MOD_D8) begin
                        enc_buf[n] = r_a_val[7:0];
                        n = n + 4'd1;
                    end else if (mod == MOD_D32) begin
                        enc_buf[n]        = r_a_val[7:0];
                        enc_buf[n + 4'd1] = r_a_val[15:8];
                        enc_buf[n + 4'd2] = r_a_val[23:16];
                        enc_buf[n + 4'd3] = r_a_val[31:24];
                        n = n + 4'd4;
                    end
                    enc_len = n;
                end
            end
            FORM_ABS: begin
                if (r_a_dst == REG_RAX) begin
                    enc_buf[0] = REX_W;
                    enc_buf[1] = OP_MOV_MOF;
                    for (int k = 0; k < 8; k++) begin
                        enc_buf[k + 2] = r_a_val[8*k +: 8];
                    end
                    enc_len = 4'd10;
                end else if (!fits32) begin
                    enc_status = ST_RANGE;
                end else begin
                    enc_buf[0] = REX_W;
                    enc_buf[1] = OP_MOV_LD;
                    enc_buf[2] = {MOD_IND, r_a_dst, RM_SIB};
                    enc_buf[3] = SIB_ABS;
                    for (int k = 0; k < 4; k++) begin
                        enc_buf[k + 4] = r_a_val[8*k +: 8];
                    end
                    enc_len = 4'd8;
                end
            end
            FORM_IMM: begin
                enc_buf[0] = REX_W;
                if (fits32) begin
                    enc_buf[1] = OP_MOV_I32;
                    enc_buf[2] = {MOD_REG, 3'b000, r_a_dst};
                    for (int k = 0; k < 4; k++) begin
                        enc_buf[k + 3] = r_a_val[8*k +: 8];
                    end
                    enc_len = 4'd7;
                end else begin
                    enc_buf[1] = OP_MOV_IMM + {5'd0, r_a_dst};
                    for (int k = 0; k < 8; k++) begin
                        enc_buf[k + 2] = r_a_val[8*k +: 8];
                    end
                    enc_len = 4'd10;
                end
            end
            default: begin
                enc_status = ST_UNSUPP;
            end
        endcase
    end

    assign b_last = (r_b_idx == r_b_len - 4'd1);
    assign b_free = !r_b_valid || (o_out.ready && b_last);
    assign a_adv  = r_a_valid && b_free;

    assign i_in.ready = !r_a_valid || b_free;

    assign o_out.valid       = r_b_valid;
    assign o_out.code_byte   = r_b_buf[r_b_idx];
    assign o_out.item_offset = r_b_offset;
    assign o_out.last_byte   = b_last;
    assign o_out.status      = r_b_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_b_idx       <= '0;
            r_b_len       <= 4'd1;
            r_text_offset <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
                r_b_idx   <= '0;
                r_b_len   <= enc_len;
                if (enc_status == ST_OK) begin
                    r_text_offset <= r_text_offset + {28'd0, enc_len};
                end
            end else if (r_b_valid && o_out.ready) begin
                if (b_last) begin
                    r_b_valid <= 1'b0;
                end else begin
                    r_b_idx <= r_b_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_opcode <= i_in.opcode;
            r_a_dst    <= i_in.dst_reg;
            r_a_src    <= i_in.src_reg;
            r_a_val    <= i_in.operand_value;
        end
        if (a_adv) begin
            r_b_buf    <= enc_buf;
            r_b_offset <= r_text_offset;
            r_b_status <= enc_status;
        end
    end

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> o_out.last_byte)
        else $error("error item not marked last");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_idx < r_b_len))
        else $error("byte index beyond instruction length");

    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !a_adv) |=> $stable(r_text_offset))
        else $error("text offset moved without an encoded item");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> i_in.ready)
        else $error("input stalled while input register empty");

endmodule

>>> tb/sv/x86_64_mov_encoder_core_tb.sv
`timescale 1ns / 100ps

import xme_pkg::*;

typedef struct packed {
    t_byte       code_byte;
    logic [31:0] item_offset;
    logic        last_byte;
    t_status     status;
} t_code_byte;

class mov_encoding_check;
    t_code_byte  owed_bytes[$];
    t_byte       enc[$];
    logic [31:0] text_off;
    int          mismatches;
    int          instrs_ok;
    int          error_items;
    int          bytes_checked;

    function new();
        text_off      = '0;
        mismatches    = 0;
        instrs_ok     = 0;
        error_items   = 0;
        bytes_checked = 0;
    endfunction

    function bit fits_sw(logic [63:0] v, int w);
        logic signed [63:0] t;
        t = v << (64 - w);
        t = t >>> (64 - w);
        return t == $signed(v);
    endfunction

    function void put_le(logic [63:0] v, int n);
        for (int k = 0; k < n; k++) begin
            enc.push_back(v[8*k +: 8]);
        end
    endfunction

    function void encode_mov(logic [2:0] op, logic [2:0] dst, logic [2:0] src,
                             logic [63:0] v);
        t_status    err;
        logic [1:0] md;
        t_code_byte r;
        err = ST_OK;
        enc.delete();
        case (op)
            FORM_RR: begin
                enc.push_back(REX_W);
                enc.push_back(OP_MOV_RM);
                enc.push_back({MOD_REG, src, dst});
            end
            FORM_BASE: begin
                if (!fits_sw(v, DISP_W)) begin
                    err = ST_RANGE;
                end else begin
                    if (v == '0 && src != REG_RBP) md = MOD_IND;
                    else if (fits_sw(v, 8))         md = MOD_D8;
                    else                            md = MOD_D32;
                    enc.push_back(REX_W);
                    enc.push_back(OP_MOV_LD);
                    enc.push_back({md, dst, src});
                    if (src == REG_RSP) enc.push_back(SIB_RSP);
                    if (md == MOD_D8)       put_le(v, 1);
                    else if (md == MOD_D32) put_le(v, 4);
                end
            end
            FORM_ABS: begin
                if (dst == REG_RAX) begin
                    enc.push_back(REX_W);
                    enc.push_back(OP_MOV_MOF);
                    put_le(v, 8);
                end else if (!fits_sw(v, 32)) begin
                    err = ST_RANGE;
                end else begin
                    enc.push_back(REX_W);
                    enc.push_back(OP_MOV_LD);
                    enc.push_back({MOD_IND, dst, RM_SIB});
                    enc.push_back(SIB_ABS);
                    put_le(v, 4);
                end
            end
            FORM_IMM: begin
                enc.push_back(REX_W);
                if (fits_sw(v, 32)) begin
                    enc.push_back(OP_MOV_I32);
                    enc.push_back({MOD_REG, 3'b000, dst});
                    put_le(v, 4);
                end else begin
                    enc.push_back(OP_MOV_IMM + {5'd0, dst});
                    put_le(v, 8);
                end
            end
            default: err = ST_UNSUPP;
        endcase

        if (err != ST_OK) begin
            r.code_byte   = '0;
            r.item_offset = text_off;
            r.last_byte   = 1'b1;
            r.status      = err;
            owed_bytes.push_back(r);
            error_items++;
        end else begin
            foreach (enc[k]) begin
                r.code_byte   = enc[k];
                r.item_offset = text_off;
                r.last_byte   = (k == enc.size() - 1);
                r.status      = ST_OK;
                owed_bytes.push_back(r);
            end
            text_off = text_off + 32'(enc.size());
            instrs_ok++;
        end
    endfunction

    function void check_byte(logic [7:0] code, logic [31:0] offs, logic last,
                             logic [1:0] st);
        t_code_byte e;
        if (owed_bytes.size() == 0) begin
            $error("unexpected byte %h at offset %h with no instruction pending", code, offs);
            mismatches++;
            return;
        end
        e = owed_bytes.pop_front();
        bytes_checked++;
        if (code !== e.code_byte) begin
            $error("code_byte: expected %h, got %h", e.code_byte, code);
            mismatches++;
        end
        if (offs !== e.item_offset) begin
            $error("item_offset: expected %h, got %h", e.item_offset, offs);
            mismatches++;
        end
        if (last !== e.last_byte) begin
            $error("last_byte: expected %b, got %b", e.last_byte, last);
            mismatches++;
        end
        if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            mismatches++;
        end
    endfunction
endclass

module x86_64_mov_encoder_core_tb;

    localparam int         CYCLE_LIMIT  = 200_000;
    localparam int         RANDOM_ITEMS = 26;
    localparam logic [2:0] FORM_UNSUPP  = 3'd4;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   send_idle_pct;
    int   stall_pct;

    xme_in_if  in_if();
    xme_out_if out_if();

    mov_encoding_check board;

    x86_64_mov_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            board.check_byte(out_if.code_byte, out_if.item_offset, out_if.last_byte,
                             out_if.status);
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_mov(input logic [2:0] op, input logic [2:0] dst,
                            input logic [2:0] src, input logic [63:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         = 1'b1;
        in_if.opcode        = op;
        in_if.dst_reg       = dst;
        in_if.src_reg       = src;
        in_if.operand_value = val;
        do @(posedge i_clk); while (!in_if.ready);
        board.encode_mov(op, dst, src, val);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = 64'($signed(8'($urandom)));
            2: v = 64'($signed(32'($urandom)));
            3: v = {$urandom, $urandom};
            4: begin
                case ($urandom_range(0, 11))
                    0:  v = 64'sd127;
                    1:  v = 64'sd128;
                    2:  v = -64'sd128;
                    3:  v = -64'sd129;
                    4:  v = 64'h0000_0000_7FFF_FFFF;
                    5:  v = 64'h0000_0000_8000_0000;
                    6:  v = 64'hFFFF_FFFF_8000_0000;
                    7:  v = 64'hFFFF_FFFF_7FFF_FFFF;
                    8:  v = 64'h7FFF_FFFF_FFFF_FFFF;
                    9:  v = 64'h8000_0000_0000_0000;
                    10: v = '1;
                    default: v = 64'd1;
                endcase
            end
            default: v = $signed({$urandom, $urandom}) >>> $urandom_range(1, 40);
        endcase
        return v;
    endfunction

    task automatic send_random_mov();
        int         r;
        logic [2:0] op;
        logic [2:0] dst;
        r   = $urandom_range(0, 99);
        dst = 3'($urandom_range(0, 7));
        if (r < 15)      op = FORM_RR;
        else if (r < 50) op = FORM_BASE;
        else if (r < 70) op = FORM_ABS;
        else if (r < 90) op = FORM_IMM;
        else             op = FORM_UNSUPP + 3'($urandom_range(0, 3));
        if (op == FORM_ABS && $urandom_range(0, 2) == 0) dst = REG_RAX;
        send_mov(op, dst, 3'($urandom_range(0, 7)), rand_operand());
    endtask

    initial begin
        board               = new();
        cycle_count         = 0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.opcode        = '0;
        in_if.dst_reg       = '0;
        in_if.src_reg       = '0;
        in_if.operand_value = '0;
        out_if.ready        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_mov(FORM_RR,   3'd7,    3'd0,    64'd0);
        send_mov(FORM_RR,   REG_RAX, 3'd7,    '1);
        send_mov(FORM_BASE, 3'd2,    REG_RAX, 64'd0);
        send_mov(FORM_BASE, 3'd1,    REG_RBP, 64'd0);
        send_mov(FORM_BASE, 3'd3,    REG_RSP, 64'd0);
        send_mov(FORM_BASE, 3'd6,    REG_RSP, -64'sd128);
        send_mov(FORM_BASE, 3'd7,    3'd7,    64'sd127);
        send_mov(FORM_BASE, REG_RAX, 3'd3,    64'sd128);
        send_mov(FORM_BASE, 3'd5,    REG_RBP, -64'sd129);
        send_mov(FORM_BASE, 3'd4,    REG_RSP, 64'h0000_0000_7FFF_FFFF);
        send_mov(FORM_BASE, 3'd2,    3'd6,    64'hFFFF_FFFF_8000_0000);
        send_mov(FORM_BASE, 3'd1,    3'd1,    64'h0000_0000_8000_0000);
        send_mov(FORM_BASE, 3'd1,    3'd2,    64'hFFFF_FFFF_7FFF_FFFF);
        send_mov(FORM_ABS,  REG_RAX, 3'd0,    64'h8000_0000_0000_0000);
        send_mov(FORM_ABS,  REG_RAX, 3'd5,    '1);
        send_mov(FORM_ABS,  3'd3,    3'd0,    64'h0000_0000_7FFF_FFFF);
        send_mov(FORM_ABS,  3'd7,    3'd0,    64'hFFFF_FFFF_8000_0000);
        send_mov(FORM_ABS,  3'd1,    3'd0,    64'h0000_0000_8000_0000);
        send_mov(FORM_IMM,  3'd2,    3'd0,    64'h0000_0000_7FFF_FFFF);
        send_mov(FORM_IMM,  3'd5,    3'd0,    64'hFFFF_FFFF_8000_0000);
        send_mov(FORM_IMM,  REG_RAX, 3'd0,    64'h0000_0000_8000_0000);
        send_mov(FORM_IMM,  3'd7,    3'd0,    64'h8000_0000_0000_0000);
        send_mov(FORM_IMM,  3'd4,    3'd0,    64'h7FFF_FFFF_FFFF_FFFF);
        send_mov(FORM_UNSUPP,  3'd7,  3'd7,   '1);
        send_mov(3'd7,      3'd0,    3'd0,    64'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                send_random_mov();
            end
        end
        in_if.valid = 1'b0;

        while (board.owed_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Encoded %0d instructions and %0d error items; %0d result bytes checked",
                 board.instrs_ok, board.error_items, board.bytes_checked);
        $display("Covered all four MOV forms, range and unsupported errors, under idle/stall mixes");
        if (board.mismatches == 0 && board.owed_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
